>>> hw/rtl/olr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// olr_pkg
// Shared widths, codes and pipeline control type of the overdub loop recorder.
// ============================================================================
package olr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 13;
  localparam int NPOS_W   = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [POS_W-1:0] LEN_RESET = 13'd4096;

  // item function codes
  localparam logic [1:0] FUNC_FRAME   = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_SETPOS  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE   = 1'b1;

  typedef struct packed {
    logic             wr;
    logic             run;
    logic [POS_W-1:0] pos;
  } olr_ctl_t;

endpackage

>>> hw/rtl/overdub_loop_recorder.sv
`timescale 1ns / 1ps
// ============================================================================
// overdub_loop_recorder
// Stereo loop recorder with overdub: read, scale by feedback, add input,
// saturate and write back into the loop store, advancing the write position.
// ============================================================================
// an accepted word passes the stage 1, stage 2 and result registers to its result word
// throughput: one word per cycle while nothing stalls; a frame at the same store
//   entry as a frame still in the read-modify-write pipe waits for its
//   write-back (loops of one or two frames)
// reset: clears every store entry in turn, no word accepted meanwhile
// each register write blocks input while the wrap position is
//   recomputed by a bit-serial remainder unit
module overdub_loop_recorder
  import olr_pkg::*;
#(
  parameter int STORE_FRAMES = 4096,
  parameter int CHANNELS     = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [POS_W-1:0]            cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  func,
  input  logic signed [SAMPLE_W-1:0]  in_left,
  input  logic signed [SAMPLE_W-1:0]  in_right,
  input  logic signed [SAMPLE_W-1:0]  fb_left,
  input  logic signed [SAMPLE_W-1:0]  fb_right,
  input  logic [NPOS_W-1:0]           new_position,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        running,
  output logic [POS_W-1:0]            position,
  output logic                        wrote,
  output logic signed [SAMPLE_W-1:0]  written_left,
  output logic signed [SAMPLE_W-1:0]  written_right
);

  localparam int AW = $clog2(STORE_FRAMES);
  localparam logic [16:0] STORE_LEN = 17'(STORE_FRAMES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_FRAMES - 1);

  // configuration and position state
  logic [POS_W-1:0] buffer_length;
  logic             loop_enable;
  logic [POS_W-1:0] pos, pos_next;
  logic             active, active_next;
  logic             wr_next;
  logic [POS_W-1:0] len_eff;
  logic [POS_W:0]   pos_inc, len_wide;

  // clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // wrap remainder unit
  logic             mod_busy, mod_load;
  logic [3:0]       mod_cnt;
  logic [POS_W:0]   mod_div;
  logic [POS_W-1:0] mod_rem;
  logic [POS_W:0]   mod_trial;

  // store
  logic [CHANNELS-1:0][SAMPLE_W-1:0] mem [STORE_FRAMES];
  logic [CHANNELS-1:0][SAMPLE_W-1:0] rd_q;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] wdata;
  logic [AW-1:0]                     a0;

  // pipeline
  logic [1:0][SAMPLE_W-1:0]          in_smp, fb_smp;
  logic                              s1_valid, s2_valid;
  olr_ctl_t                          s1c, s2c;
  logic [AW-1:0]                     s1_addr, s2_addr;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] s1_in, s1_fb, s2_in;
  logic [CHANNELS-1:0][31:0]         prod, s2_prod;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] val;
  logic                              out_en, s2_en, s1_en, accept, hold;

  assign len_eff  = ({4'b0, buffer_length} > STORE_LEN) ? POS_W'(STORE_LEN) : buffer_length;
  assign pos_inc  = {1'b0, pos} + 14'd1;
  assign len_wide = {1'b0, len_eff};
  assign a0       = AW'(pos);

  assign out_en = !result_valid || !result_stall;
  assign s2_en  = !s2_valid || out_en;
  assign s1_en  = !s1_valid || s2_en;
  assign hold   = (s1_valid && s1c.wr && s1_addr == a0) ||
                  (s2_valid && s2c.wr && s2_addr == a0);
  assign item_stall = !s1_en || clr_busy || mod_busy || hold;
  assign accept     = item_valid && !item_stall;

  // next position and run flag of the word at the input
  always_comb begin
    pos_next    = pos;
    active_next = active;
    wr_next     = 1'b0;
    case (func)
      FUNC_RESTART: begin
        active_next = 1'b1;
        pos_next    = '0;
      end
      FUNC_SETPOS: begin
        pos_next = (new_position > {3'b0, len_eff}) ? len_eff : new_position[POS_W-1:0];
      end
      FUNC_FRAME: begin
        if (active && len_eff != '0) begin
          wr_next  = (pos < len_eff);
          pos_next = pos_inc[POS_W-1:0];
          if (pos_inc >= len_wide) begin
            if (loop_enable) begin
              if (pos_inc == len_wide) begin
                pos_next = '0;
              end else if (pos_inc == len_wide + 14'd1) begin
                pos_next = (len_eff == 13'd1) ? '0 : 13'd1;
              end else begin
                pos_next = mod_rem;
              end
            end else begin
              active_next = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= LEN_RESET;
      loop_enable   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BUFFER_LENGTH: buffer_length <= cfg_data;
        REG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      active <= 1'b1;
    end else if (accept) begin
      pos    <= pos_next;
      active <= active_next;
    end
  end

  // remainder of (pos + 1) by the loop length, for a position left beyond it
  assign mod_trial = {mod_rem, mod_div[POS_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      mod_load <= 1'b0;
    end else if (cfg_write) begin
      mod_busy <= 1'b1;
      mod_load <= 1'b1;
    end else if (mod_busy) begin
      if (mod_load) begin
        mod_load <= 1'b0;
      end else if (mod_cnt == '0) begin
        mod_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mod_busy) begin
      if (mod_load) begin
        mod_div <= pos_inc;
        mod_rem <= '0;
        mod_cnt <= 4'(POS_W);
      end else begin
        mod_div <= {mod_div[POS_W-1:0], 1'b0};
        mod_cnt <= mod_cnt - 4'd1;
        if (mod_trial >= len_wide) begin
          mod_rem <= POS_W'(mod_trial - len_wide);
        end else begin
          mod_rem <= mod_trial[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // store, read-first
  assign we    = clr_busy || (s2_valid && s2c.wr && out_en);
  assign waddr = clr_busy ? clr_addr : s2_addr;
  assign wdata = clr_busy ? '0 : val;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      rd_q <= mem[a0];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    in_smp = {in_right, in_left};
    fb_smp = {fb_right, fb_left};
  end

  // stage 1 multiply, stage 2 scale, add and saturate
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod[c] = $signed(s1_fb[c]) * $signed(rd_q[c]);
    end
  end

  always_comb begin
    logic signed [17:0] sum;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = {s2_prod[c][31], s2_prod[c][31:15]} +
            {{2{s2_in[c][SAMPLE_W-1]}}, s2_in[c]};
      if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
        val[c] = sum[SAMPLE_W-1:0];
      end else if (sum[17]) begin
        val[c] = 16'h8000;
      end else begin
        val[c] = 16'h7fff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= accept;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && accept) begin
      s1c.wr  <= wr_next;
      s1c.run <= active_next;
      s1c.pos <= pos_next;
      s1_addr <= a0;
      s1_in   <= in_smp[CHANNELS-1:0];
      s1_fb   <= fb_smp[CHANNELS-1:0];
    end
    if (s2_en && s1_valid) begin
      s2c     <= s1c;
      s2_addr <= s1_addr;
      s2_in   <= s1_in;
      s2_prod <= prod;
    end
    if (out_en && s2_valid) begin
      running       <= s2c.run;
      position      <= s2c.pos;
      wrote         <= s2c.wr;
      written_left  <= s2c.wr ? val[0] : '0;
      written_right <= (CHANNELS > 1 && s2c.wr) ? val[CHANNELS-1] : '0;
    end
  end

`ifndef SYNTHESIS
  a_no_pending_overlap: assert property (@(posedge clk) disable iff (rst)
    (we && !clr_busy && s1_valid && s1c.wr) |-> (waddr != s1_addr))
    else $error("write-back hits an entry still being read");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!s1_valid && !s2_valid && !result_valid))
    else $error("word in flight during store clear");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !wrote) |-> (written_left == '0 && written_right == '0))
    else $error("written sample nonzero without a write");
`endif

endmodule
